>>> rtl/rvex_pkg.sv
// rvex_pkg: shared types and codes for the RV32IM execute unit.
// No dependencies.
`default_nettype none
package rvex_pkg;

    localparam logic [2:0] MODE_LUI    = 3'd0;
    localparam logic [2:0] MODE_AUIPC  = 3'd1;
    localparam logic [2:0] MODE_ALUI   = 3'd2;
    localparam logic [2:0] MODE_ALUR   = 3'd3;
    localparam logic [2:0] MODE_JAL    = 3'd4;
    localparam logic [2:0] MODE_JALR   = 3'd5;
    localparam logic [2:0] MODE_BRANCH = 3'd6;

    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    // funct3 of the base ALU operations
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SR   = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // funct3 of multiply and divide
    localparam logic [2:0] F3_MUL    = 3'd0;
    localparam logic [2:0] F3_MULH   = 3'd1;
    localparam logic [2:0] F3_MULHSU = 3'd2;
    localparam logic [2:0] F3_MULHU  = 3'd3;
    localparam logic [2:0] F3_DIV    = 3'd4;
    localparam logic [2:0] F3_DIVU   = 3'd5;
    localparam logic [2:0] F3_REM    = 3'd6;
    localparam logic [2:0] F3_REMU   = 3'd7;

    // funct3 of branch conditions
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;
    localparam logic [2:0] F3_BLT  = 3'd4;
    localparam logic [2:0] F3_BGE  = 3'd5;
    localparam logic [2:0] F3_BLTU = 3'd6;
    localparam logic [2:0] F3_BGEU = 3'd7;

    // operation class chosen in the first stage
    typedef enum logic [2:0] {
        OP_NONE,
        OP_SIMPLE,
        OP_MUL,
        OP_DIV,
        OP_BRANCH
    } t_op;

    // sideband carried alongside the divider
    typedef struct packed {
        t_op         op;
        logic [2:0]  funct3;
        logic [31:0] simple;
        logic        wr;
        logic [4:0]  rd;
        logic [31:0] npc;
        logic        taken;
        logic        illegal;
        logic        neg_q;
        logic        neg_r;
        logic [31:0] a_raw;
        logic        div_zero;
        logic        ovf;
        logic [63:0] prod;
    } t_ctl;

endpackage
`default_nettype wire

>>> rtl/rv32im_execute_unit.sv
// rv32im_execute_unit: top level of the RV32IM execute stage.
// Depends on rvex_pkg and rvex_div_pipe.
//
//  channel | valid   | ready   | payload
//  in      | i_valid | o_ready | i_mode i_funct3 i_funct7 i_pc i_a_value i_b_value
//          |         |         | i_offset i_rd_index
//  out     | o_valid | i_ready | o_rd_value o_rd_write o_rd_out o_next_pc o_taken
//          |         |         | o_illegal
//
// One item per cycle when the pipe is not stalled. Each item passes the decode
// and multiply stage, the divider stages, then result select feeding the output
// register. The whole pipe advances when the output register is empty or
// being taken, so a stall holds every stage. Reset clears the valid bits only.
`default_nettype none
module rv32im_execute_unit #(
    parameter int DIGITS = 4
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire [2:0]   i_mode,
    input  wire [2:0]   i_funct3,
    input  wire [6:0]   i_funct7,
    input  wire [31:0]  i_pc,
    input  wire [31:0]  i_a_value,
    input  wire [31:0]  i_b_value,
    input  wire [31:0]  i_offset,
    input  wire [4:0]   i_rd_index,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [31:0] o_rd_value,
    output logic        o_rd_write,
    output logic [4:0]  o_rd_out,
    output logic [31:0] o_next_pc,
    output logic        o_taken,
    output logic        o_illegal
);
    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // ---- stage 1: simple ALU, branch, multiply, divider operand prep
    rvex_pkg::t_ctl n_c1, r_c1;
    logic [31:0]    n_num, n_den, r_num, r_den;
    logic           r_v1;

    always_comb begin
        logic [31:0] a, b, sum, sh_l, sh_rl, sh_ra;
        logic [4:0]  sh;
        logic        lt_s, lt_u, f7z, alt, md;
        logic [32:0] ma, mb;
        logic [65:0] p;
        a = i_a_value; b = i_b_value; sh = b[4:0];
        sum = a + b;
        sh_l = a << sh; sh_rl = a >> sh; sh_ra = $unsigned($signed(a) >>> sh);
        lt_s = $signed(a) < $signed(b); lt_u = a < b;
        f7z = i_funct7 == rvex_pkg::F7_BASE;
        alt = i_funct7 == rvex_pkg::F7_ALT;
        n_c1 = '0;
        n_c1.funct3 = i_funct3;
        n_c1.rd = i_rd_index;
        n_c1.npc = i_pc + 32'd4;
        n_c1.a_raw = a;
        n_num = a; n_den = b;
        md = 1'b0;
        unique case (i_mode)
            rvex_pkg::MODE_LUI: begin
                n_c1.op = rvex_pkg::OP_SIMPLE; n_c1.wr = 1'b1; n_c1.simple = a;
            end
            rvex_pkg::MODE_AUIPC: begin
                n_c1.op = rvex_pkg::OP_SIMPLE; n_c1.wr = 1'b1; n_c1.simple = i_pc + a;
            end
            rvex_pkg::MODE_ALUI, rvex_pkg::MODE_ALUR: begin
                n_c1.op = rvex_pkg::OP_SIMPLE; n_c1.wr = 1'b1;
                unique case (i_funct3)
                    rvex_pkg::F3_ADD:  n_c1.simple = sum;
                    rvex_pkg::F3_SLL:  n_c1.simple = sh_l;
                    rvex_pkg::F3_SLT:  n_c1.simple = {31'd0, lt_s};
                    rvex_pkg::F3_SLTU: n_c1.simple = {31'd0, lt_u};
                    rvex_pkg::F3_XOR:  n_c1.simple = a ^ b;
                    rvex_pkg::F3_SR:   n_c1.simple = f7z ? sh_rl : sh_ra;
                    rvex_pkg::F3_OR:   n_c1.simple = a | b;
                    default:           n_c1.simple = a & b;
                endcase
                if (i_mode == rvex_pkg::MODE_ALUR && !f7z) begin
                    if (alt && i_funct3 == rvex_pkg::F3_ADD) n_c1.simple = a - b;
                    else if (alt && i_funct3 == rvex_pkg::F3_SR) n_c1.simple = sh_ra;
                    else md = 1'b1;
                end
            end
            rvex_pkg::MODE_JAL: begin
                n_c1.op = rvex_pkg::OP_SIMPLE; n_c1.wr = 1'b1;
                n_c1.simple = i_pc + 32'd4; n_c1.npc = i_pc + a; n_c1.taken = 1'b1;
            end
            rvex_pkg::MODE_JALR: begin
                n_c1.op = rvex_pkg::OP_SIMPLE; n_c1.wr = 1'b1;
                n_c1.simple = i_pc + 32'd4; n_c1.npc = {sum[31:1], 1'b0};
                n_c1.taken = 1'b1;
            end
            rvex_pkg::MODE_BRANCH: begin
                n_c1.op = rvex_pkg::OP_BRANCH;
                unique case (i_funct3)
                    rvex_pkg::F3_BEQ:  n_c1.taken = a == b;
                    rvex_pkg::F3_BNE:  n_c1.taken = a != b;
                    rvex_pkg::F3_BLT:  n_c1.taken = lt_s;
                    rvex_pkg::F3_BGE:  n_c1.taken = !lt_s;
                    rvex_pkg::F3_BLTU: n_c1.taken = lt_u;
                    rvex_pkg::F3_BGEU: n_c1.taken = !lt_u;
                    default: n_c1.illegal = 1'b1;
                endcase
                if (n_c1.taken) n_c1.npc = i_pc + i_offset;
            end
            default: n_c1.op = rvex_pkg::OP_NONE;
        endcase
        // multiply: 33x33 signed covers all four flavours
        ma = {(i_funct3 == rvex_pkg::F3_MULH || i_funct3 == rvex_pkg::F3_MULHSU) & a[31], a};
        mb = {(i_funct3 == rvex_pkg::F3_MULH) & b[31], b};
        p = 66'($signed(ma) * $signed(mb));
        if (md) begin
            n_c1.prod = p[63:0];
            // funct3 bit 2 marks divide and remainder, bit 0 the unsigned forms
            if (i_funct3[2]) begin
                n_c1.op = rvex_pkg::OP_DIV;
                n_c1.div_zero = b == 32'd0;
                n_c1.ovf = a == 32'h8000_0000 && b == 32'hFFFF_FFFF;
                if (!i_funct3[0]) begin
                    n_num = a[31] ? 32'd0 - a : a;
                    n_den = b[31] ? 32'd0 - b : b;
                    n_c1.neg_q = a[31] ^ b[31];
                    n_c1.neg_r = a[31];
                end
            end else begin
                n_c1.op = rvex_pkg::OP_MUL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else if (en) r_v1 <= i_valid;
        if (en) begin
            r_c1 <= n_c1; r_num <= n_num; r_den <= n_den;
        end
    end

    // ---- divider stages (every item passes through to keep order)
    logic           dv;
    logic [31:0]    quo, rem;
    rvex_pkg::t_ctl c2;

    rvex_div_pipe #(.DIGITS(DIGITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_en(en), .i_valid(r_v1),
        .i_num(r_num), .i_den(r_den), .i_ctl(r_c1),
        .o_valid(dv), .o_quo(quo), .o_rem(rem), .o_ctl(c2)
    );

    // ---- result select into output register
    logic [31:0] n_val;
    always_comb begin
        logic [31:0] q, r;
        q = c2.neg_q ? 32'd0 - quo : quo;
        r = c2.neg_r ? 32'd0 - rem : rem;
        unique case (c2.op)
            rvex_pkg::OP_SIMPLE: n_val = c2.simple;
            rvex_pkg::OP_MUL:    n_val = (c2.funct3 == rvex_pkg::F3_MUL) ? c2.prod[31:0]
                                                                         : c2.prod[63:32];
            rvex_pkg::OP_DIV: begin
                // funct3 bit 1 picks remainder over quotient
                if (!c2.funct3[1]) begin
                    if (c2.div_zero) n_val = 32'hFFFF_FFFF;
                    else if (c2.ovf && !c2.funct3[0]) n_val = 32'h8000_0000;
                    else n_val = q;
                end else begin
                    if (c2.div_zero) n_val = c2.a_raw;
                    else if (c2.ovf && !c2.funct3[0]) n_val = 32'd0;
                    else n_val = r;
                end
            end
            default: n_val = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else if (en) o_valid <= dv;
        if (en) begin
            o_rd_value <= n_val;
            o_rd_write <= c2.wr;
            o_rd_out   <= c2.rd;
            o_next_pc  <= c2.npc;
            o_taken    <= c2.taken;
            o_illegal  <= c2.illegal;
        end
    end
endmodule
`default_nettype wire

>>> rtl/rvex_div_pipe.sv
// rvex_div_pipe: pipelined unsigned 32/32 divider, DIGITS quotient bits per stage.
// Depends on rvex_pkg for the sideband struct.
`default_nettype none
module rvex_div_pipe #(
    parameter int DIGITS = 4
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_en,
    input  wire          i_valid,
    input  wire [31:0]   i_num,
    input  wire [31:0]   i_den,
    input  wire rvex_pkg::t_ctl i_ctl,
    output logic         o_valid,
    output logic [31:0]  o_quo,
    output logic [31:0]  o_rem,
    output rvex_pkg::t_ctl o_ctl
);
    localparam int STAGES = 32 / DIGITS;

    // restoring division, DIGITS steps between registers
    for (genvar s = 0; s < STAGES; s++) begin : g_st
        logic           v_in;
        logic [31:0]    q_in, r_in, d_in;
        rvex_pkg::t_ctl c_in;
        logic [31:0]    n_q, n_r;
        logic           r_v;
        logic [31:0]    r_q, r_r, r_d;
        rvex_pkg::t_ctl r_c;

        // stage input: block inputs for the first stage, previous stage after
        if (s == 0) begin : g_head
            assign v_in = i_valid;
            assign q_in = i_num;
            assign r_in = 32'd0;
            assign d_in = i_den;
            assign c_in = i_ctl;
        end else begin : g_link
            assign v_in = g_st[s-1].r_v;
            assign q_in = g_st[s-1].r_q;
            assign r_in = g_st[s-1].r_r;
            assign d_in = g_st[s-1].r_d;
            assign c_in = g_st[s-1].r_c;
        end

        // partial remainder stays below the divisor, so 32 bits between stages
        always_comb begin
            logic [32:0] w, t;
            n_q = q_in;
            w = {1'b0, r_in};
            for (int k = 0; k < DIGITS; k++) begin
                w = {w[31:0], n_q[31]};
                n_q = {n_q[30:0], 1'b0};
                t = w - {1'b0, d_in};
                if (!t[32]) begin
                    w = t;
                    n_q[0] = 1'b1;
                end
            end
            n_r = w[31:0];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_en) begin
                r_v <= v_in;
            end
            if (i_en) begin
                r_q <= n_q;
                r_r <= n_r;
                r_d <= d_in;
                r_c <= c_in;
            end
        end
    end

    assign o_valid = g_st[STAGES-1].r_v;
    assign o_quo   = g_st[STAGES-1].r_q;
    assign o_rem   = g_st[STAGES-1].r_r;
    assign o_ctl   = g_st[STAGES-1].r_c;
endmodule
`default_nettype wire

>>> verif/rv32im_execute_unit_tb.sv
// rv32im_execute_unit_tb: self-checking testbench for the RV32IM execute stage.
// Depends on rvex_pkg and rv32im_execute_unit; predicts every result in a scoreboard class.
`timescale 1ns / 100ps
module rv32im_execute_unit_tb;

    typedef struct packed {
        logic [2:0]  mode;
        logic [2:0]  funct3;
        logic [6:0]  funct7;
        logic [31:0] pc;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] offset;
        logic [4:0]  rd;
    } t_instr;

    typedef struct packed {
        logic [31:0] value;
        logic        wr;
        logic [4:0]  rd;
        logic [31:0] npc;
        logic        taken;
        logic        illegal;
    } t_wb;

    // execute-stage predictor and queue of pending writebacks
    class exec_scoreboard;
        t_wb pending[$];
        int  mismatches;

        function logic [31:0] sra(logic [31:0] a, logic [4:0] s);
            return $signed(a) >>> s;
        endfunction

        function logic [31:0] base_alu(logic [2:0] f3, logic [6:0] f7,
                                       logic [31:0] a, logic [31:0] b);
            logic [4:0] sh;
            sh = b[4:0];
            case (f3)
                rvex_pkg::F3_ADD:  return a + b;
                rvex_pkg::F3_SLL:  return a << sh;
                rvex_pkg::F3_SLT:  return {31'd0, $signed(a) < $signed(b)};
                rvex_pkg::F3_SLTU: return {31'd0, a < b};
                rvex_pkg::F3_XOR:  return a ^ b;
                rvex_pkg::F3_SR:   return (f7 == rvex_pkg::F7_BASE) ? a >> sh : sra(a, sh);
                rvex_pkg::F3_OR:   return a | b;
                default:           return a & b;
            endcase
        endfunction

        function logic [31:0] muldiv(logic [2:0] f3, logic [31:0] a, logic [31:0] b);
            logic [63:0] p;
            logic [31:0] ma, mb, q;
            ma = a[31] ? -a : a;
            mb = b[31] ? -b : b;
            case (f3)
                rvex_pkg::F3_MUL: return a * b;
                rvex_pkg::F3_MULH: begin
                    p = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                    return p[63:32];
                end
                rvex_pkg::F3_MULHSU: begin
                    p = {{32{a[31]}}, a} * {32'd0, b};
                    return p[63:32];
                end
                rvex_pkg::F3_MULHU: begin
                    p = {32'd0, a} * {32'd0, b};
                    return p[63:32];
                end
                rvex_pkg::F3_DIV: begin
                    if (b == 32'd0) return '1;
                    if (a == 32'h8000_0000 && b == '1) return a;
                    q = ma / mb;
                    return (a[31] ^ b[31]) ? -q : q;
                end
                rvex_pkg::F3_DIVU: return (b == 32'd0) ? '1 : a / b;
                rvex_pkg::F3_REM: begin
                    if (b == 32'd0) return a;
                    if (a == 32'h8000_0000 && b == '1) return 32'd0;
                    q = ma % mb;
                    return a[31] ? -q : q;
                end
                default: return (b == 32'd0) ? a : a % b;
            endcase
        endfunction

        function void note_instr(t_instr t);
            t_wb w;
            w = '0;
            w.rd = t.rd;
            w.npc = t.pc + 32'd4;
            case (t.mode)
                rvex_pkg::MODE_LUI: begin w.value = t.a; w.wr = 1'b1; end
                rvex_pkg::MODE_AUIPC: begin w.value = t.pc + t.a; w.wr = 1'b1; end
                rvex_pkg::MODE_ALUI: begin
                    w.value = base_alu(t.funct3, t.funct7, t.a, t.b); w.wr = 1'b1;
                end
                rvex_pkg::MODE_ALUR: begin
                    w.wr = 1'b1;
                    if (t.funct7 == rvex_pkg::F7_BASE)
                        w.value = base_alu(t.funct3, rvex_pkg::F7_BASE, t.a, t.b);
                    else if (t.funct7 == rvex_pkg::F7_ALT && t.funct3 == rvex_pkg::F3_ADD)
                        w.value = t.a - t.b;
                    else if (t.funct7 == rvex_pkg::F7_ALT && t.funct3 == rvex_pkg::F3_SR)
                        w.value = sra(t.a, t.b[4:0]);
                    else
                        w.value = muldiv(t.funct3, t.a, t.b);
                end
                rvex_pkg::MODE_JAL: begin
                    w.value = t.pc + 32'd4; w.wr = 1'b1; w.npc = t.pc + t.a; w.taken = 1'b1;
                end
                rvex_pkg::MODE_JALR: begin
                    w.value = t.pc + 32'd4; w.wr = 1'b1;
                    w.npc = (t.a + t.b) & ~32'd1; w.taken = 1'b1;
                end
                rvex_pkg::MODE_BRANCH: begin
                    case (t.funct3)
                        rvex_pkg::F3_BEQ:  w.taken = t.a == t.b;
                        rvex_pkg::F3_BNE:  w.taken = t.a != t.b;
                        rvex_pkg::F3_BLT:  w.taken = $signed(t.a) < $signed(t.b);
                        rvex_pkg::F3_BGE:  w.taken = $signed(t.a) >= $signed(t.b);
                        rvex_pkg::F3_BLTU: w.taken = t.a < t.b;
                        rvex_pkg::F3_BGEU: w.taken = t.a >= t.b;
                        default: w.illegal = 1'b1;
                    endcase
                    if (w.taken) w.npc = t.pc + t.offset;
                end
                default: ;
            endcase
            pending.push_back(w);
        endfunction

        function void check_wb(t_wb got);
            t_wb e;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
                return;
            end
            e = pending.pop_front();
            if (got !== e) begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch: expected %p, got %p", e, got);
            end
        endfunction
    endclass

    logic i_clk = 0, i_rst_n = 0, i_valid = 0, i_ready = 0;
    logic [2:0] i_mode = 0, i_funct3 = 0;
    logic [6:0] i_funct7 = 0;
    logic [31:0] i_pc = 0, i_a_value = 0, i_b_value = 0, i_offset = 0;
    logic [4:0] i_rd_index = 0;
    logic o_ready, o_valid, o_rd_write, o_taken, o_illegal;
    logic [31:0] o_rd_value, o_next_pc;
    logic [4:0] o_rd_out;

    exec_scoreboard sb = new();
    bit long_hold = 0;

    rv32im_execute_unit dut (.*);

    always #2 i_clk = ~i_clk;

    // input acceptance and output checking
    always @(posedge i_clk) if (i_rst_n) begin
        if (i_valid && o_ready)
            sb.note_instr({i_mode, i_funct3, i_funct7, i_pc, i_a_value, i_b_value,
                           i_offset, i_rd_index});
        if (o_valid && i_ready)
            sb.check_wb({o_rd_value, o_rd_write, o_rd_out, o_next_pc, o_taken, o_illegal});
    end

    // receiver: own stall pattern, plus at least one long hold-off
    always @(posedge i_clk) begin
        if (long_hold) i_ready <= 0;
        else case ($urandom_range(0, 3))
            0: i_ready <= ($urandom_range(0, 3) == 0);
            default: i_ready <= 1;
        endcase
    end

    function logic [31:0] edge_word();
        case ($urandom_range(0, 7))
            0: return 32'd0;
            1: return 32'd1;
            2: return '1;
            3: return 32'h8000_0000;
            4: return 32'h7fff_ffff;
            5: return $urandom_range(0, 40);
            default: return $urandom;
        endcase
    endfunction

    task automatic send(t_instr t);
        i_valid <= 1;
        {i_mode, i_funct3, i_funct7, i_pc, i_a_value, i_b_value, i_offset, i_rd_index} <= t;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic idle(int n);
        i_valid <= 0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_random();
        t_instr t;
        t.mode = 3'($urandom_range(0, 7));
        t.funct3 = 3'($urandom);
        case ($urandom_range(0, 3))
            0: t.funct7 = rvex_pkg::F7_BASE;
            1: t.funct7 = rvex_pkg::F7_ALT;
            2: t.funct7 = 7'h01;
            default: t.funct7 = 7'($urandom);
        endcase
        t.pc = $urandom;
        t.a = edge_word();
        t.b = ($urandom_range(0, 3) == 0) ? t.a : edge_word();
        t.offset = edge_word();
        t.rd = 5'($urandom);
        send(t);
    endtask

    initial begin
        t_instr t;
        int burst;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: each class, division corners, bad branch conditions
        for (int f = 0; f < 8; f++) begin
            t = '{rvex_pkg::MODE_ALUR, f[2:0], 7'h01, 32'hffff_fffc, 32'h8000_0000,
                  '1, '1, 5'd31};
            send(t);
            t.b = 0;
            send(t);
        end
        for (int m = 0; m < 8; m++) begin
            t = '{m[2:0], rvex_pkg::F3_SLT, rvex_pkg::F7_ALT, '1, '1, 32'h7fff_ffff,
                  32'h8000_0000, 5'd0};
            send(t);
        end
        // undefined branch condition
        t = '{rvex_pkg::MODE_BRANCH, 3'd3, rvex_pkg::F7_BASE, 32'd0, 32'd5, 32'd5, 32'd8, 5'd1};
        send(t);
        t = '{rvex_pkg::MODE_ALUI, rvex_pkg::F3_SR, rvex_pkg::F7_ALT, 32'd0, 32'h8000_0000,
              32'd63, 32'd0, 5'd2};
        send(t);
        // random bursts with gaps
        for (int n = 0; n < 1000; n += burst) begin
            burst = $urandom_range(1, 30);
            repeat (burst) send_random();
            if (n > 300 && n < 331) begin
                // long receiver hold-off while items keep coming
                fork
                    begin long_hold = 1; repeat (200) @(posedge i_clk); long_hold = 0; end
                    repeat (40) send_random();
                join
            end
            if (n > 600 && n < 631) begin
                i_valid <= 0;
                @(posedge i_clk);
                while (sb.pending.size() != 0) @(posedge i_clk);
            end
            if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 6));
        end
        i_valid <= 0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end
endmodule
